// ===== rtl/spr_pkg.sv =====
`timescale 1ns / 1ps
package spr_pkg;

	localparam int MAX_BINS  = 4096;
	localparam int MAG_BITS  = 24;
	localparam int FRAC_BITS = 16;
	localparam int CNT_W     = 13;
	localparam int IDX_W     = 12;
	localparam int OUT_W     = 28;

	// divider datapath: numerator is num<<FRAC plus den, compared against 2*den<<(FRAC+1)
	localparam int DEN_W  = MAG_BITS + 1;
	localparam int DIV_W  = DEN_W + 1 + FRAC_BITS + 1;
	localparam int Q_W    = FRAC_BITS + 1;
	localparam int STEP_W = $clog2(FRAC_BITS + 1);
	localparam int SUM_W  = IDX_W + FRAC_BITS + 1;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef struct packed {
		logic [MAG_BITS-1:0] magnitude;
		logic                last_bin;
	} bin_beat_t;

	typedef struct packed {
		logic [OUT_W-1:0] refined_bin_q16;
		logic [IDX_W-1:0] peak_index;
		logic             short_spectrum;
	} result_beat_t;

	// one finished spectrum, handed from the front to the divider
	typedef struct packed {
		logic [MAG_BITS-1:0] y0;
		logic [MAG_BITS-1:0] y1;
		logic [MAG_BITS-1:0] y2;
		logic [IDX_W-1:0]    peak_index;
		logic                short_spectrum;
	} peak_t;

endpackage

// ===== rtl/spectral_peak_parabolic_refine.sv =====
`timescale 1ns / 1ps
// bins are taken one per cycle; the front stalls only when both queue slots hold spectra
// a result passes the queue, the prep states ST_MAG and ST_LOAD, the restoring divider
// and a finish state ST_DONE; short or flat peaks skip the divider
// the shared divider takes a new spectrum from the queue only once it is through with the last
// arst_n clears the bin tracker, the queue pointers and count, and the result valid flag; no result is pending
module spectral_peak_parabolic_refine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  bin_valid,
	output logic                  bin_ready,
	input  spr_pkg::bin_beat_t    bin,
	output logic                  result_valid,
	input  logic                  result_ready,
	output spr_pkg::result_beat_t result
);
	import spr_pkg::*;

	logic  q_full;
	logic  q_push;
	logic  q_valid;
	logic  q_pop;
	peak_t push_data;
	peak_t pop_data;

	spr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_valid (bin_valid),
		.bin_ready (bin_ready),
		.bin       (bin),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (push_data)
	);

	spr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.not_empty (q_valid),
		.pop       (q_pop),
		.pop_data  (pop_data)
	);

	spr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_data       (pop_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== rtl/spr_front.sv =====
`timescale 1ns / 1ps
module spr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               bin_valid,
	output logic               bin_ready,
	input  spr_pkg::bin_beat_t bin,
	input  logic               q_full,
	output logic               push,
	output spr_pkg::peak_t     push_data
);
	import spr_pkg::*;

	logic [CNT_W-1:0]    cnt_q;
	logic [MAG_BITS-1:0] best_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [MAG_BITS-1:0] prev_q;
	logic [MAG_BITS-1:0] left_q;
	logic [MAG_BITS-1:0] right_q;
	logic                pend_q;

	logic             accept;
	logic             active;
	logic             take;
	logic [CNT_W-1:0] cnt_next;

	assign bin_ready = !q_full;
	assign accept    = bin_valid && bin_ready;
	assign active    = cnt_q < CNT_W'(MAX_BINS);
	assign cnt_next  = active ? cnt_q + CNT_W'(1) : cnt_q;

	// inner bins only: skip bin 0 and anything that could be the last bin
	assign take = active && !bin.last_bin && (cnt_q >= CNT_W'(1))
		&& (cnt_q <= CNT_W'(MAX_BINS - 2))
		&& ((cnt_q == CNT_W'(1)) || (bin.magnitude > best_q));

	assign push = accept && bin.last_bin;

	always_comb begin
		push_data.y0             = left_q;
		push_data.y1             = best_q;
		push_data.y2             = (active && pend_q) ? bin.magnitude : right_q;
		push_data.peak_index     = best_idx_q;
		push_data.short_spectrum = cnt_next < CNT_W'(3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			prev_q     <= '0;
			left_q     <= '0;
			right_q    <= '0;
			pend_q     <= 1'b0;
		end else if (accept) begin
			if (bin.last_bin) begin
				cnt_q      <= '0;
				best_q     <= '0;
				best_idx_q <= '0;
				prev_q     <= '0;
				left_q     <= '0;
				right_q    <= '0;
				pend_q     <= 1'b0;
			end else if (active) begin
				if (pend_q) begin
					right_q <= bin.magnitude;
				end
				pend_q <= take;
				if (take) begin
					best_q     <= bin.magnitude;
					best_idx_q <= cnt_q[IDX_W-1:0];
					left_q     <= prev_q;
				end
				prev_q <= bin.magnitude;
				cnt_q  <= cnt_next;
			end
		end
	end

endmodule

// ===== rtl/spr_queue.sv =====
`timescale 1ns / 1ps
module spr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spr_pkg::peak_t push_data,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output spr_pkg::peak_t pop_data
);
	import spr_pkg::*;

	peak_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full      = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !full)
		else $error("spectrum queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("spectrum queue underrun");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("spectrum queue count out of range");
`endif

endmodule

// ===== rtl/spr_back.sv =====
`timescale 1ns / 1ps
module spr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  spr_pkg::peak_t        q_data,
	output logic                  result_valid,
	input  logic                  result_ready,
	output spr_pkg::result_beat_t result
);
	import spr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	peak_t               ent_q;
	logic [DEN_W-1:0]    den_mag_q;
	logic [MAG_BITS-1:0] num_mag_q;
	logic                den_zero_q;
	logic                neg_q;
	logic                ovf_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    dsh_q;
	logic [Q_W-1:0]      quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                res_valid_q;
	result_beat_t        res_q;

	logic [DEN_W-1:0]    sum;
	logic [DEN_W-1:0]    twice;
	logic                den_neg;
	logic                num_neg;
	logic [DEN_W-1:0]    den_mag;
	logic [MAG_BITS-1:0] num_mag;
	logic [DIV_W-1:0]    n_val;
	logic [DEN_W:0]      d_val;
	logic                ovf;
	logic                ge;
	logic [Q_W-1:0]      q_sat;
	logic [SUM_W-1:0]    base;
	logic [SUM_W-1:0]    q_ext;
	logic [SUM_W-1:0]    refined;
	logic                out_free;

	assign q_pop        = (state_q == ST_IDLE) && q_valid;
	assign out_free     = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		sum     = {1'b0, ent_q.y0} + {1'b0, ent_q.y2};
		twice   = {ent_q.y1, 1'b0};
		den_neg = sum < twice;
		den_mag = den_neg ? twice - sum : sum - twice;
		num_neg = ent_q.y0 < ent_q.y2;
		num_mag = num_neg ? ent_q.y2 - ent_q.y0 : ent_q.y0 - ent_q.y2;

		// rounded quotient: (num<<F + den) / (2*den)
		n_val = {{(DIV_W-MAG_BITS-FRAC_BITS){1'b0}}, num_mag_q, {FRAC_BITS{1'b0}}}
			+ {{(DIV_W-DEN_W){1'b0}}, den_mag_q};
		d_val = {den_mag_q, 1'b0};
		ovf   = n_val >= {d_val, {(FRAC_BITS+1){1'b0}}};

		ge = rem_q >= dsh_q;

		if (den_zero_q) begin
			q_sat = '0;
		end else if (ovf_q || (quo_q > Q_W'(1 << FRAC_BITS))) begin
			q_sat = Q_W'(1 << FRAC_BITS);
		end else begin
			q_sat = quo_q;
		end
		base  = {1'b0, ent_q.peak_index, {FRAC_BITS{1'b0}}};
		q_ext = {{(SUM_W-Q_W){1'b0}}, q_sat};
		if (neg_q) begin
			refined = (base < q_ext) ? '0 : base - q_ext;
		end else begin
			refined = base + q_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= (ent_q.short_spectrum || den_zero_q) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ent_q <= q_data;
			end
			ST_MAG: begin
				den_mag_q  <= den_mag;
				num_mag_q  <= num_mag;
				den_zero_q <= sum == twice;
				neg_q      <= num_neg != den_neg;
			end
			ST_LOAD: begin
				rem_q  <= n_val;
				dsh_q  <= {1'b0, d_val, {FRAC_BITS{1'b0}}};
				ovf_q  <= ovf;
				quo_q  <= '0;
				step_q <= STEP_W'(FRAC_BITS);
			end
			ST_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q  <= {quo_q[Q_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q - STEP_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					if (ent_q.short_spectrum) begin
						res_q.refined_bin_q16 <= '0;
						res_q.peak_index      <= '0;
						res_q.short_spectrum  <= 1'b1;
					end else begin
						res_q.refined_bin_q16 <= refined[OUT_W-1:0];
						res_q.peak_index      <= ent_q.peak_index;
						res_q.short_spectrum  <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_div_exits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> (state_q == ST_DIV || state_q == ST_DONE))
		else $error("divider left its loop the wrong way");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !ovf_q) |-> ((rem_q >> 1) < dsh_q))
		else $error("divider remainder out of range");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_valid_q && !result_ready) |=> (state_q == ST_DONE))
		else $error("result written over a pending beat");
`endif

endmodule
